@@ hw/rtl/hebp_pkg.sv @@
// Package for the Huffman encoder bit packer: sizes, op codes and the
// item passed from the table stage to the packer. No dependencies.
package hebp_pkg;

    localparam int NUM_SYMBOLS  = 256;
    localparam int MAX_CODE_LEN = 32;

    localparam int SYM_W   = 8;
    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int SYM_AW  = $clog2(NUM_SYMBOLS);

    localparam int IN_DATA_W = ((SYM_W + CODE_W + LEN_W + 7) / 8) * 8;

    // bytes one symbol can complete, and the packing window
    localparam int OUT_BYTES = (MAX_CODE_LEN + 7) / 8;
    localparam int OUT_W     = OUT_BYTES * 8;
    localparam int NB_W      = $clog2(OUT_BYTES + 1);
    localparam int PACK_W    = ((MAX_CODE_LEN + 15) / 8) * 8;
    localparam int TOT_W     = $clog2(MAX_CODE_LEN + 8);

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]              op;
        logic [LEN_W-1:0]        len;
        logic [MAX_CODE_LEN-1:0] word;
    } t_pack_item;

endpackage

@@ hw/rtl/hebp_packer.sv @@
// Bit packer: merges a looked-up code with the pending bits and streams
// out completed bytes. Depends on hebp_pkg.
module hebp_packer
    import hebp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_pack_item       i_item,
    output logic             o_ready,
    output logic             o_tvalid,
    input  logic             i_tready,
    output logic [7:0]       o_tdata,
    output logic             o_tlast
);

    logic [7:0]        r_pend_byte, n_pend_byte;
    logic [2:0]        r_pend_cnt, n_pend_cnt;
    logic [OUT_W-1:0]  r_e_data;
    logic [NB_W-1:0]   r_e_cnt;

    logic [MAX_CODE_LEN-1:0] code_lj;
    logic [PACK_W-1:0]       packed_bits, shifted;
    logic [TOT_W-1:0]        total;
    logic [NB_W-1:0]         nb;
    logic [OUT_W-1:0]        out_bytes;
    logic                    e_free, advance, out_hs;

    always_comb begin
        code_lj     = i_item.word << (LEN_W'(MAX_CODE_LEN) - i_item.len);
        packed_bits = {r_pend_byte, (PACK_W-8)'(0)}
                    | (PACK_W'(code_lj) << (4'd8 - {1'b0, r_pend_cnt}));
        total       = TOT_W'(r_pend_cnt) + TOT_W'(i_item.len);
        shifted     = '0;
        nb          = '0;
        out_bytes   = packed_bits[PACK_W-1 -: OUT_W];
        n_pend_byte = r_pend_byte;
        n_pend_cnt  = r_pend_cnt;
        case (i_item.op)
            OP_ENCODE: begin
                if (i_item.len != '0) begin
                    nb          = NB_W'(total >> 3);
                    shifted     = packed_bits << {nb, 3'b000};
                    n_pend_byte = shifted[PACK_W-1 -: 8];
                    n_pend_cnt  = total[2:0];
                end
            end
            OP_FLUSH: begin
                if (r_pend_cnt != '0) begin
                    nb          = NB_W'(1);
                    out_bytes   = {r_pend_byte, (OUT_W-8)'(0)};
                    n_pend_byte = '0;
                    n_pend_cnt  = '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign out_hs  = o_tvalid && i_tready;
    assign e_free  = (r_e_cnt == '0) || ((r_e_cnt == NB_W'(1)) && i_tready);
    assign o_ready = (nb == '0) || e_free;
    assign advance = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_byte <= '0;
            r_pend_cnt  <= '0;
            r_e_cnt     <= '0;
        end else begin
            if (advance) begin
                r_pend_byte <= n_pend_byte;
                r_pend_cnt  <= n_pend_cnt;
            end
            if (advance && (nb != '0)) begin
                r_e_cnt <= nb;
            end else if (out_hs) begin
                r_e_cnt <= r_e_cnt - NB_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && (nb != '0)) begin
            r_e_data <= out_bytes;
        end else if (out_hs) begin
            r_e_data <= r_e_data << 8;
        end
    end

    assign o_tvalid = (r_e_cnt != '0);
    assign o_tdata  = r_e_data[OUT_W-1 -: 8];
    assign o_tlast  = (r_e_cnt == NB_W'(1));

endmodule

@@ hw/rtl/huffman_encode_bit_packer.sv @@
// A byte is offered once its item has passed the table read register and then been packed
// into the output register (table read, then pack).
// Throughput: one item per cycle while the output register can accept; an item completing
// bytes holds the output register until all are taken, stalling a later item that completes bytes.
// Table lengths use per-entry valid bits, so no clearing pass is needed after reset.
// Reset (i_rst_n, synchronous, active low) clears the length valid bits, pending bits and the pipeline.
// Top level: code table and lookup stage; instantiates hebp_packer. Depends on hebp_pkg.
module huffman_encode_bit_packer
    import hebp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,  // symbol, code_bits, code_len, zero pad
    input  logic [1:0]           s_axis_tuser,  // op
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,  // out_byte
    output logic                 m_axis_tlast
);

    logic [CODE_W-1:0] code_mem [NUM_SYMBOLS];
    logic [LEN_W-1:0]  len_mem  [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0] r_len_vld;

    logic              r_s1_valid;
    logic [1:0]        r_s1_op;
    logic              r_s1_hit;
    logic [CODE_W-1:0] r_s1_word;
    logic [LEN_W-1:0]  r_s1_len;

    logic [SYM_W-1:0]  in_sym;
    logic [CODE_W-1:0] in_bits;
    logic [LEN_W-1:0]  in_len;
    logic [SYM_AW-1:0] idx;
    logic              in_range, accept, load_ok, pk_ready;
    t_pack_item        pk_item;

    assign in_sym   = s_axis_tdata[SYM_W-1:0];
    assign in_bits  = s_axis_tdata[SYM_W +: CODE_W];
    assign in_len   = s_axis_tdata[SYM_W+CODE_W +: LEN_W];
    assign idx      = in_sym[SYM_AW-1:0];
    assign in_range = ({1'b0, in_sym} < (SYM_W+1)'(NUM_SYMBOLS));

    assign s_axis_tready = !r_s1_valid || pk_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign load_ok       = accept && (t_op'(s_axis_tuser) == OP_LOAD) && in_range
                         && ({1'b0, in_len} <= (LEN_W+1)'(MAX_CODE_LEN));

    always_ff @(posedge i_clk) begin
        if (load_ok) begin
            code_mem[idx] <= in_bits;
            len_mem[idx]  <= in_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_word <= code_mem[idx];
            r_s1_len  <= len_mem[idx];
            r_s1_op   <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_vld  <= '0;
            r_s1_valid <= 1'b0;
            r_s1_hit   <= 1'b0;
        end else begin
            if (load_ok) begin
                r_len_vld[idx] <= 1'b1;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_s1_hit   <= in_range && r_len_vld[idx];
            end else if (pk_ready) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        pk_item.op   = r_s1_op;
        pk_item.len  = r_s1_hit ? r_s1_len : '0;
        pk_item.word = MAX_CODE_LEN'(r_s1_word);
    end

    hebp_packer u_packer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s1_valid),
        .i_item   (pk_item),
        .o_ready  (pk_ready),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

endmodule

@@ hw/rtl/hebp_checker.sv @@
// Port-level checks for huffman_encode_bit_packer, attached by bind.
// Depends on hebp_pkg.
module hebp_checker
    import hebp_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [7:0]           m_axis_tdata,
    input logic                 m_axis_tlast
);

    a_rst_out_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output word offered straight after reset");

    a_rst_in_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready straight after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word withdrawn while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

endmodule

bind huffman_encode_bit_packer hebp_checker u_hebp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

@@ bench/tb_huffman_encode_bit_packer.sv @@
// Self-checking bench for huffman_encode_bit_packer: table loads, encodes, flushes
// and reserved ops, with a byte-level predictor in a scoreboard class.
// Depends on hebp_pkg and the huffman_encode_bit_packer RTL.
`timescale 1ns / 1ps

module tb_huffman_encode_bit_packer;
    import hebp_pkg::*;

    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_coded_byte;

    class huff_byte_scoreboard;
        bit [CODE_W-1:0] code_word [NUM_SYMBOLS];
        bit [LEN_W-1:0]  code_len  [NUM_SYMBOLS];
        bit [7:0]        acc_byte;
        bit [2:0]        acc_count;
        t_coded_byte     expected_bytes [$];
        int              errors;
        int              bytes_checked;

        function new();
            foreach (code_len[i]) code_len[i] = '0;
            acc_byte = '0;
            acc_count = '0;
            errors = 0;
            bytes_checked = 0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void note_word(logic [1:0] op, logic [7:0] sym, logic [31:0] code,
                                logic [5:0] len);
            int n;
            int pos;
            t_coded_byte e;
            n = 0;
            case (op)
                OP_LOAD: begin
                    if (len <= MAX_CODE_LEN) begin
                        code_word[sym] = code;
                        code_len[sym]  = len;
                    end
                end
                OP_ENCODE: begin
                    for (pos = int'(code_len[sym]) - 1; pos >= 0; pos--) begin
                        acc_byte[7 - acc_count] = code_word[sym][pos];
                        if (acc_count == 3'd7) begin
                            e.value = acc_byte;
                            e.last  = 1'b0;
                            expected_bytes.push_back(e);
                            acc_byte  = '0;
                            acc_count = '0;
                            n++;
                        end else begin
                            acc_count++;
                        end
                    end
                    if (n > 0) expected_bytes[expected_bytes.size() - 1].last = 1'b1;
                end
                OP_FLUSH: begin
                    if (acc_count != 0) begin
                        e.value = acc_byte;
                        e.last  = 1'b1;
                        expected_bytes.push_back(e);
                        acc_byte  = '0;
                        acc_count = '0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_byte(logic [7:0] value, logic last);
            t_coded_byte e;
            bytes_checked++;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected byte %02h last %0b", $time, value, last);
                errors++;
                return;
            end
            e = expected_bytes.pop_front();
            if (value !== e.value) begin
                $display("%0t: out_byte expected %02h got %02h", $time, e.value, value);
                errors++;
            end
            if (last !== e.last) begin
                $display("%0t: last expected %0b got %0b", $time, e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;   // symbol, code_bits, code_len, zero pad
    logic [1:0]           s_axis_tuser = '0;   // op
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;        // out_byte
    logic                 m_axis_tlast;

    huff_byte_scoreboard sb = new();
    bit          no_idle = 1'b0;
    bit          rx_hold_req = 1'b0;
    int unsigned cycles = 0;
    int unsigned words_taken = 0;
    logic [7:0]  loaded_syms [$];

    huffman_encode_bit_packer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d bytes still expected", $time, sb.pending());
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_byte(m_axis_tdata, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready) begin
                words_taken++;
                sb.note_word(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[39:8],
                             s_axis_tdata[45:40]);
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end
            m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 30);
        end
    end

    task automatic send_word(input logic [1:0] op, input logic [7:0] sym,
                             input logic [31:0] code, input logic [5:0] len);
        int unsigned gap;
        gap = (!no_idle && $urandom_range(99) < 30) ? $urandom_range(1, 3) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, len, code, sym};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [5:0] pick_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5) return 6'd0;
        if (r < 80) return 6'($urandom_range(1, 12));
        if (r < 95) return 6'($urandom_range(13, 32));
        return 6'($urandom_range(33, 63));
    endfunction

    task automatic send_load(input logic [7:0] sym, input logic [31:0] code,
                             input logic [5:0] len);
        send_word(OP_LOAD, sym, code, len);
        if (len != 0 && len <= MAX_CODE_LEN) loaded_syms.push_back(sym);
    endtask

    initial begin
        int unsigned pick;
        logic [7:0]  sym;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: length extremes, rejected long codes, unused symbols, flushes
        send_word(OP_LOAD, 8'd0,   32'h0000_0001, 6'd1);
        send_word(OP_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32);
        send_word(OP_LOAD, 8'd1,   32'h0000_00A5, 6'd8);
        send_word(OP_LOAD, 8'd2,   32'h0000_0000, 6'd7);
        send_word(OP_LOAD, 8'd3,   32'h8000_0001, 6'd32);
        send_word(OP_LOAD, 8'd4,   32'hFFFF_FFFF, 6'd33);
        send_word(OP_LOAD, 8'd1,   32'hFFFF_FFFF, 6'd63);
        send_word(OP_LOAD, 8'd6,   32'h1234_5678, 6'd0);
        send_word(OP_ENCODE, 8'd1, 32'hFFFF_FFFF, 6'h3F);
        send_word(OP_ENCODE, 8'd0, 32'h0, 6'd0);
        send_word(OP_ENCODE, 8'd2, 32'h0, 6'd0);
        send_word(OP_ENCODE, 8'd255, 32'h0, 6'd0);
        send_word(OP_ENCODE, 8'd0, 32'h0, 6'd0);
        send_word(OP_ENCODE, 8'd3, 32'h0, 6'd0);
        send_word(OP_ENCODE, 8'd4, 32'h0, 6'd0);
        send_word(OP_ENCODE, 8'd6, 32'h0, 6'd0);
        send_word(OP_ENCODE, 8'd200, 32'h0, 6'd0);
        send_word(OP_FLUSH, 8'd0, 32'h0, 6'd0);
        send_word(OP_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        send_word(OP_RESERVED, 8'd1, 32'hFFFF_FFFF, 6'h3F);
        send_word(OP_ENCODE, 8'd2, 32'h0, 6'd0);
        send_word(OP_FLUSH, 8'd0, 32'h0, 6'd0);
        wait_drained();

        for (int k = 0; k < 24; k++) begin
            send_load(8'($urandom_range(255)), $urandom, pick_len());
        end
        rx_hold_req = 1'b1;

        for (int k = 0; k < 326; k++) begin
            if (k == 100) no_idle = 1'b1;
            if (k == 200) no_idle = 1'b0;
            if (k == 250) wait_drained();
            pick = $urandom_range(99);
            if (loaded_syms.size() != 0)
                sym = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
            else
                sym = 8'($urandom_range(255));
            if (pick < 8)
                send_load(8'($urandom_range(255)), $urandom, pick_len());
            else if (pick < 82)
                send_word(OP_ENCODE, sym, $urandom, 6'($urandom_range(63)));
            else if (pick < 94)
                send_word(OP_FLUSH, 8'($urandom_range(255)), $urandom, 6'($urandom_range(63)));
            else if (pick < 97)
                send_word(OP_RESERVED, sym, $urandom, 6'($urandom_range(63)));
            else
                send_word(OP_ENCODE, 8'($urandom_range(255)), $urandom, 6'($urandom_range(63)));
        end
        send_word(OP_FLUSH, 8'd0, 32'h0, 6'd0);

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("Run covered %0d input words (loads, encodes, flushes, reserved ops)",
                 words_taken);
        $display("and %0d output bytes, under random stalls and a long output hold-off.",
                 sb.bytes_checked);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
